FILE: rtl/kms_pkg.sv
// Shared types, constants and keypad usage table for the keypad matrix scanner.
package kms_pkg;

    localparam int SENSE_W = 7;
    localparam logic [SENSE_W-1:0] RELEASED_INIT = 7'h73;
    localparam int TABLE_COLS = 4;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // Usage codes indexed by {column[1:0], sense bit[2:0]}; bit 7 slots are empty.
    localparam logic [7:0] USAGE_TABLE [32] = '{
        8'h53, 8'h5F, 8'h00, 8'h00, 8'h5C, 8'h59, 8'h62, 8'h00,
        8'h54, 8'h60, 8'h00, 8'h00, 8'h5D, 8'h5A, 8'h00, 8'h00,
        8'h55, 8'h61, 8'h00, 8'h00, 8'h5E, 8'h5B, 8'h63, 8'h00,
        8'h56, 8'h57, 8'h00, 8'h00, 8'h00, 8'h58, 8'h00, 8'h00
    };

    // One classified sample waiting for the report generator
    typedef struct packed {
        logic [1:0]         col;
        logic               in_table;
        logic [4:0]         base;
        logic [SENSE_W-1:0] cur;
        logic [SENSE_W-1:0] diff;
    } kms_item_t;

    function automatic logic [7:0] usage_at(logic [1:0] col, logic [2:0] bit_idx);
        return USAGE_TABLE[{col, bit_idx}];
    endfunction

endpackage

FILE: rtl/keypad_matrix_scanner_unit.sv
// Top level of the keypad matrix scanner: front end, sample queue and report generator.
// A scan sample is taken while the two-entry sample queue has room; a sample
// with no change on the wired rows only advances the column and queues nothing. The report
// generator emits one report per clock while its output is empty or popped; a sample
// with n changed keys gives n reports (at most 7) via queue, item and output registers.
// Column histories and the sense mask reset to 0x73; writes to the mask belong to idle time.
module keypad_matrix_scanner_unit #(
    parameter int COLUMNS = 4,
    parameter int ROWS    = 7
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       push,
    output logic       full,
    input  logic [6:0] sense_bits,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] scan_column,
    output logic [4:0] key_index,
    output logic       pressed,
    output logic [7:0] report_key,
    output logic       last
);
    import kms_pkg::*;

    logic      in_fire;
    logic      item_push;
    kms_item_t front_item;
    kms_item_t q_item;
    logic      q_valid, q_full, q_pop;

    assign full    = q_full;
    assign in_fire = push && !full;

    kms_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .sense_bits  (sense_bits),
        .item_push   (item_push),
        .item        (front_item)
    );

    kms_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (item_push),
        .wr_item (front_item),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .q_valid (q_valid),
        .q_full  (q_full)
    );

    kms_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .scan_column (scan_column),
        .key_index   (key_index),
        .pressed     (pressed),
        .report_key  (report_key),
        .last        (last)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        item_push |-> !q_full)
        else $error("sample queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("sample queue read while empty");

    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pressed) |-> (report_key == 8'h00))
        else $error("release transaction carries a usage code");

endmodule

FILE: rtl/kms_front.sv
// Front end: masks each sample, compares with the column history and classifies it.
module kms_front #(
    parameter int COLUMNS = 4,
    parameter int ROWS    = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [kms_pkg::SENSE_W-1:0] cfg_wr_data,
    input  logic                     in_fire,
    input  logic [kms_pkg::SENSE_W-1:0] sense_bits,
    output logic                     item_push,
    output kms_pkg::kms_item_t       item
);
    import kms_pkg::*;

    localparam int CW  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int LIM = (ROWS < SENSE_W) ? ROWS : SENSE_W;
    localparam logic [SENSE_W-1:0] LIMIT_MASK = SENSE_W'((1 << LIM) - 1);

    logic [CW-1:0]      col_reg, col_next;
    logic [SENSE_W-1:0] mask_reg;
    logic [SENSE_W-1:0] prev_reg [COLUMNS];
    logic [SENSE_W-1:0] cur;
    logic [SENSE_W-1:0] diff;
    logic [7:0]         base_full;

    assign cur       = sense_bits & mask_reg;
    assign diff      = (cur ^ prev_reg[col_reg]) & LIMIT_MASK;
    assign base_full = 8'(col_reg) * 8'(ROWS);
    assign col_next  = (col_reg == CW'(COLUMNS - 1)) ? '0 : col_reg + CW'(1);

    assign item_push     = in_fire && (diff != '0);
    assign item.col      = 2'(col_reg);
    assign item.in_table = 5'(col_reg) < 5'(TABLE_COLS);
    assign item.base     = base_full[4:0];
    assign item.cur      = cur;
    assign item.diff     = diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            mask_reg <= RELEASED_INIT;
            for (int c = 0; c < COLUMNS; c++)
            begin
                prev_reg[c] <= RELEASED_INIT;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                prev_reg[col_reg] <= cur;
                col_reg           <= col_next;
            end
        end
    end

endmodule

FILE: rtl/kms_queue.sv
// Two-entry queue of classified samples between front and back end.
module kms_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  kms_pkg::kms_item_t wr_item,
    input  logic               rd_en,
    output kms_pkg::kms_item_t rd_item,
    output logic               q_valid,
    output logic               q_full
);
    import kms_pkg::*;

    kms_item_t          mem [QDEPTH];
    logic [QPTR_W-1:0]  wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign q_valid = count_reg != '0;
    assign q_full  = count_reg == QCNT_W'(QDEPTH);
    assign rd_item = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + QPTR_W'(1);
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + QPTR_W'(1);
            end
            unique case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/kms_back.sv
// Back end: walks a sample's changed bits to an output register, one per cycle while free.
module kms_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  kms_pkg::kms_item_t q_item,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [1:0]         scan_column,
    output logic [4:0]         key_index,
    output logic               pressed,
    output logic [7:0]         report_key,
    output logic               last
);
    import kms_pkg::*;

    logic               busy_reg;
    kms_item_t          item_reg;
    logic [SENSE_W-1:0] rem_reg, rem_after;
    logic               out_valid_reg;
    logic [1:0]         col_out_reg;
    logic [4:0]         key_out_reg;
    logic               pressed_out_reg;
    logic [7:0]         usage_out_reg;
    logic               last_out_reg;

    logic       out_ready, emit, done, load;
    logic [2:0] sel;
    logic       down;

    // lowest set bit of the remaining change mask
    always_comb
    begin
        sel = '0;
        for (int i = SENSE_W - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                sel = 3'(i);
            end
        end
    end

    assign rem_after = rem_reg & ~(SENSE_W'(1) << sel);
    assign out_ready = !out_valid_reg || pop;
    assign emit      = busy_reg && out_ready;
    assign done      = rem_after == '0;
    assign load      = q_valid && (!busy_reg || (emit && done));
    assign q_pop     = load;
    assign down      = !item_reg.cur[sel];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit && done)
            begin
                busy_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= q_item;
            rem_reg  <= q_item.diff;
        end
        else if (emit)
        begin
            rem_reg <= rem_after;
        end
        if (emit)
        begin
            col_out_reg     <= item_reg.col;
            key_out_reg     <= item_reg.base + 5'(sel);
            pressed_out_reg <= down;
            usage_out_reg   <= (down && item_reg.in_table) ? usage_at(item_reg.col, sel) : 8'h00;
            last_out_reg    <= done;
        end
    end

    assign empty       = !out_valid_reg;
    assign scan_column = col_out_reg;
    assign key_index   = key_out_reg;
    assign pressed     = pressed_out_reg;
    assign report_key  = usage_out_reg;
    assign last        = last_out_reg;

endmodule
